/* rtl/core/dll_pkg.sv */
// ----------------------------------------------------------------------------
// dll_pkg
// Shared types and constants for the doubly linked list manager: operation
// codes, sequencer states and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package dll_pkg;

  // fixed port field widths
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned FIELD_W = 6;

  // default size of the node pool
  localparam int unsigned NODES_DEF = 64;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    K_PUSH_TAIL = 4'd0,
    K_PUSH_HEAD = 4'd1,
    K_POP_HEAD  = 4'd2,
    K_POP_TAIL  = 4'd3,
    K_INS_BEF   = 4'd4,
    K_INS_AFT   = 4'd5,
    K_REMOVE    = 4'd6,
    K_INSPECT   = 4'd7,
    K_CLEAR     = 4'd8
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_RD,
    ST_LD,
    ST_WR1,
    ST_WR2,
    ST_OUT
  } state_e;

endpackage

/* rtl/core/dll_ram.sv */
// ----------------------------------------------------------------------------
// dll_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/doubly_linked_list_manager.sv */
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Keeps one doubly linked list over a pool of node indices: head, tail,
// per-node next and prev links in two RAMs and per-node membership flops.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req_valid_i with kind_i, node_i, anchor_i; a word is
//   taken when req_valid_i is high and req_stall_o is low. Result channel:
//   res_valid_o with the result fields; a word leaves when res_valid_o is
//   high and res_stall_i is low.
//   One operation at a time. A sequencer drives the single write and read
//   port of each link RAM: decode, optional link read (address, then data),
//   the write state WR1 and, where needed, WR2, then the result word. The
//   next request is taken only once the result has left and the sequencer
//   is back in its idle state.
//   The result is held unchanged in its register while res_stall_i is high,
//   and no new request is taken until it has left.
//   Reset empties the list and clears every membership bit at once; link
//   RAM contents are not reset, they are only read for member nodes.
//   Only node indices below both NODES and 64 can ever be members.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager
  import dll_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               req_valid_i,
  output logic               req_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [FIELD_W-1:0] node_i,
  input  logic [FIELD_W-1:0] anchor_i,
  // result channel
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic               ok_o,
  output logic               out_valid_o,
  output logic [FIELD_W-1:0] out_node_o,
  output logic               is_member_o,
  output logic               has_prev_o,
  output logic [FIELD_W-1:0] prev_node_o,
  output logic               has_next_o,
  output logic [FIELD_W-1:0] next_node_o,
  output logic               has_head_o,
  output logic [FIELD_W-1:0] head_node_o,
  output logic               has_tail_o,
  output logic [FIELD_W-1:0] tail_node_o
);

  // nodes reachable through a node field
  localparam int unsigned FIELD_SPAN = 2 ** FIELD_W;
  localparam int unsigned POOL   = (NODES < FIELD_SPAN) ? NODES : FIELD_SPAN;
  localparam int unsigned IDX_W  = $clog2(POOL);
  localparam int unsigned LINK_W = IDX_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  // sequencer and list state
  state_e             state_q, state_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [FIELD_W-1:0] n_q, n_d;
  logic [FIELD_W-1:0] a_q, a_d;
  idx_t               tgt_q, tgt_d;
  link_t              p_q, p_d;
  link_t              x_q, x_d;
  idx_t               head_q, head_d;
  idx_t               tail_q, tail_d;
  logic               nonempty_q, nonempty_d;
  logic [POOL-1:0]    member_q, member_d;

  // result word registers
  logic               ok_q, ok_d;
  logic               ov_q, ov_d;
  logic [FIELD_W-1:0] on_q, on_d;
  logic               hp_q, hp_d;
  logic [FIELD_W-1:0] pn_q, pn_d;
  logic               hn_q, hn_d;
  logic [FIELD_W-1:0] nn_q, nn_d;

  // link ram ports
  logic  nxt_we, prv_we;
  idx_t  nxt_wa, prv_wa;
  link_t nxt_wd, prv_wd;
  idx_t  rd_addr;
  link_t nxt_rd, prv_rd;

  // decode helpers
  idx_t n_idx, a_idx;
  logic n_in_pool, a_in_pool, n_mem, a_mem, can_add, dec_go;
  logic p_v, x_v;
  idx_t p_i, x_i;

  assign n_idx     = n_q[IDX_W-1:0];
  assign a_idx     = a_q[IDX_W-1:0];
  assign n_in_pool = ({{(32-FIELD_W){1'b0}}, n_q} < 32'(POOL));
  assign a_in_pool = ({{(32-FIELD_W){1'b0}}, a_q} < 32'(POOL));
  assign n_mem     = n_in_pool && member_q[n_idx];
  assign a_mem     = a_in_pool && member_q[a_idx];
  assign can_add   = n_in_pool && !member_q[n_idx];
  assign p_v       = p_q[IDX_W];
  assign p_i       = p_q[IDX_W-1:0];
  assign x_v       = x_q[IDX_W];
  assign x_i       = x_q[IDX_W-1:0];

  // whether the decoded operation goes ahead
  always_comb begin
    case (kind_q)
      K_PUSH_TAIL, K_PUSH_HEAD: dec_go = can_add;
      K_POP_HEAD, K_POP_TAIL:   dec_go = nonempty_q;
      K_INS_BEF, K_INS_AFT:     dec_go = can_add && a_mem;
      K_REMOVE, K_INSPECT:      dec_go = n_mem;
      K_CLEAR:                  dec_go = 1'b1;
      default:                  dec_go = 1'b0;
    endcase
  end

  // link rams
  dll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_wa),
    .wdata_i (nxt_wd),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rd)
  );

  dll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_wa),
    .wdata_i (prv_wd),
    .raddr_i (rd_addr),
    .rdata_o (prv_rd)
  );

  assign rd_addr = tgt_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_DEC;
      end
      ST_DEC: begin
        if (!dec_go || kind_q == K_CLEAR) begin
          state_d = ST_OUT;
        end else if (kind_q == K_PUSH_TAIL || kind_q == K_PUSH_HEAD) begin
          state_d = ST_WR1;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_LD;
      ST_LD: begin
        state_d = (kind_q == K_INSPECT) ? ST_OUT : ST_WR1;
      end
      ST_WR1: begin
        if (kind_q == K_INS_BEF || kind_q == K_INS_AFT) begin
          state_d = ST_WR2;
        end else if ((kind_q == K_PUSH_TAIL || kind_q == K_PUSH_HEAD) && nonempty_q) begin
          state_d = ST_WR2;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_WR2: state_d = ST_OUT;
      ST_OUT: begin
        if (!res_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control per state
  always_comb begin
    kind_d     = kind_q;
    n_d        = n_q;
    a_d        = a_q;
    tgt_d      = tgt_q;
    p_d        = p_q;
    x_d        = x_q;
    head_d     = head_q;
    tail_d     = tail_q;
    nonempty_d = nonempty_q;
    member_d   = member_q;
    ok_d       = ok_q;
    ov_d       = ov_q;
    on_d       = on_q;
    hp_d       = hp_q;
    pn_d       = pn_q;
    hn_d       = hn_q;
    nn_d       = nn_q;
    nxt_we     = 1'b0;
    nxt_wa     = n_idx;
    nxt_wd     = '0;
    prv_we     = 1'b0;
    prv_wa     = n_idx;
    prv_wd     = '0;

    case (state_q)
      // take the request word and clear the result
      ST_IDLE: begin
        if (req_valid_i) begin
          kind_d = kind_i;
          n_d    = node_i;
          a_d    = anchor_i;
          ok_d   = 1'b0;
          ov_d   = 1'b0;
          on_d   = '0;
          hp_d   = 1'b0;
          pn_d   = '0;
          hn_d   = 1'b0;
          nn_d   = '0;
        end
      end

      // decide, pick the node whose links are read, and empty the list for clear
      ST_DEC: begin
        ok_d = dec_go;
        case (kind_q)
          K_POP_HEAD: begin
            tgt_d = head_q;
            ov_d  = dec_go;
            on_d  = dec_go ? FIELD_W'(head_q) : '0;
          end
          K_POP_TAIL: begin
            tgt_d = tail_q;
            ov_d  = dec_go;
            on_d  = dec_go ? FIELD_W'(tail_q) : '0;
          end
          K_INS_BEF, K_INS_AFT: tgt_d = a_idx;
          K_CLEAR: begin
            member_d   = '0;
            nonempty_d = 1'b0;
            head_d     = '0;
            tail_d     = '0;
          end
          default: tgt_d = n_idx;
        endcase
      end

      // capture the links read from the rams
      ST_LD: begin
        p_d = prv_rd;
        x_d = nxt_rd;
        if (kind_q == K_INSPECT) begin
          hp_d = prv_rd[IDX_W];
          pn_d = prv_rd[IDX_W] ? FIELD_W'(prv_rd[IDX_W-1:0]) : '0;
          hn_d = nxt_rd[IDX_W];
          nn_d = nxt_rd[IDX_W] ? FIELD_W'(nxt_rd[IDX_W-1:0]) : '0;
        end
      end

      // first write cycle
      ST_WR1: begin
        case (kind_q)
          K_PUSH_TAIL, K_PUSH_HEAD: begin
            if (!nonempty_q) begin
              nxt_we         = 1'b1;
              prv_we         = 1'b1;
              head_d         = n_idx;
              tail_d         = n_idx;
              nonempty_d     = 1'b1;
              member_d[n_idx] = 1'b1;
            end else if (kind_q == K_PUSH_TAIL) begin
              nxt_we = 1'b1;
              nxt_wa = tail_q;
              nxt_wd = {1'b1, n_idx};
              prv_we = 1'b1;
              prv_wd = {1'b1, tail_q};
            end else begin
              prv_we = 1'b1;
              prv_wa = head_q;
              prv_wd = {1'b1, n_idx};
              nxt_we = 1'b1;
              nxt_wd = {1'b1, head_q};
            end
          end
          K_INS_BEF: begin
            prv_we = 1'b1;
            prv_wd = p_q;
            nxt_we = 1'b1;
            nxt_wd = {1'b1, a_idx};
          end
          K_INS_AFT: begin
            nxt_we = 1'b1;
            nxt_wd = x_q;
            prv_we = 1'b1;
            prv_wd = {1'b1, a_idx};
          end
          // unlink the target for pops and remove
          default: begin
            if (p_v) begin
              nxt_we = 1'b1;
              nxt_wa = p_i;
              nxt_wd = x_q;
              if (x_v) begin
                prv_we = 1'b1;
                prv_wa = x_i;
                prv_wd = p_q;
              end else begin
                tail_d = p_i;
              end
            end else if (x_v) begin
              head_d = x_i;
              prv_we = 1'b1;
              prv_wa = x_i;
              prv_wd = '0;
            end else begin
              nonempty_d = 1'b0;
              head_d     = '0;
              tail_d     = '0;
            end
            member_d[tgt_q] = 1'b0;
          end
        endcase
      end

      // second write cycle
      ST_WR2: begin
        member_d[n_idx] = 1'b1;
        case (kind_q)
          K_PUSH_TAIL: begin
            nxt_we = 1'b1;
            tail_d = n_idx;
          end
          K_PUSH_HEAD: begin
            prv_we = 1'b1;
            head_d = n_idx;
          end
          K_INS_BEF: begin
            prv_we = 1'b1;
            prv_wa = a_idx;
            prv_wd = {1'b1, n_idx};
            if (p_v) begin
              nxt_we = 1'b1;
              nxt_wa = p_i;
              nxt_wd = {1'b1, n_idx};
            end else begin
              head_d = n_idx;
            end
          end
          K_INS_AFT: begin
            nxt_we = 1'b1;
            nxt_wa = a_idx;
            nxt_wd = {1'b1, n_idx};
            if (x_v) begin
              prv_we = 1'b1;
              prv_wa = x_i;
              prv_wd = {1'b1, n_idx};
            end else begin
              tail_d = n_idx;
            end
          end
          default: ;
        endcase
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      nonempty_q <= 1'b0;
      member_q   <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      nonempty_q <= nonempty_d;
      member_q   <= member_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    n_q    <= n_d;
    a_q    <= a_d;
    tgt_q  <= tgt_d;
    p_q    <= p_d;
    x_q    <= x_d;
    ok_q   <= ok_d;
    ov_q   <= ov_d;
    on_q   <= on_d;
    hp_q   <= hp_d;
    pn_q   <= pn_d;
    hn_q   <= hn_d;
    nn_q   <= nn_d;
  end

  // port outputs
  assign req_stall_o = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign ok_o        = ok_q;
  assign out_valid_o = ov_q;
  assign out_node_o  = on_q;
  assign is_member_o = n_mem;
  assign has_prev_o  = hp_q;
  assign prev_node_o = pn_q;
  assign has_next_o  = hn_q;
  assign next_node_o = nn_q;
  assign has_head_o  = nonempty_q;
  assign head_node_o = nonempty_q ? FIELD_W'(head_q) : '0;
  assign has_tail_o  = nonempty_q;
  assign tail_node_o = nonempty_q ? FIELD_W'(tail_q) : '0;

endmodule
